// ===== rtl/pdirt_pkg.sv =====
// shared types, segment codes and timing constants for the pulse distance ir transmitter
// no dependencies

package pdirt_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned FrameW = 48;
    localparam int unsigned TickW  = 8;
    localparam int unsigned BitCntW = 6;
    localparam int unsigned PhaseW = 3;

    localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
    localparam logic [PhaseW-1:0] PH_HDR_MARK  = 3'd1;
    localparam logic [PhaseW-1:0] PH_HDR_SPACE = 3'd2;
    localparam logic [PhaseW-1:0] PH_BIT_MARK  = 3'd3;
    localparam logic [PhaseW-1:0] PH_BIT_SPACE = 3'd4;
    localparam logic [PhaseW-1:0] PH_STOP_MARK = 3'd5;
    localparam logic [PhaseW-1:0] PH_GAP_SPACE = 3'd6;
    localparam logic [PhaseW-1:0] PH_UNUSED    = 3'd7;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic MODE_NEC = 1'b0;
    localparam logic MODE_TRI = 1'b1;

    localparam logic [TickW-1:0] NEC_LEAD_MARK  = 8'd180;
    localparam logic [TickW-1:0] NEC_LEAD_SPACE = 8'd90;
    localparam logic [TickW-1:0] NEC_SPACE_ONE  = 8'd34;
    localparam logic [TickW-1:0] MED_HDR        = 8'd88;
    localparam logic [TickW-1:0] MED_ONE_SPACE  = 8'd32;
    localparam logic [TickW-1:0] MED_GAP_SPACE  = 8'd88;
    localparam logic [TickW-1:0] UNIT_TICKS     = 8'd11;

    localparam logic [BitCntW-1:0] NEC_BITS = 6'd32;
    localparam logic [BitCntW-1:0] MED_BITS = 6'd48;

    typedef struct packed {
        logic             req_type;
        logic             frame_mode;
        logic [DataW-1:0] frame_data;
    } in_t;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic start_rejected;
    } out_t;

    typedef struct packed {
        logic busy;
        logic mark;
    } status_t;

endpackage

// ===== rtl/pulse_distance_ir_transmitter.sv =====
// top level of the tick-driven pulse distance ir transmitter
// depends on pdirt_pkg, pdirt_seq and pdirt_obuf

// Every beat (a start request or one 50 us tick) is processed when it is accepted: the sequencer updates
// its frame state at the accepting edge and the matching result enters a two-entry
// output queue at the same edge, so beats may arrive back to back. s_ready drops only
// while both queue entries hold results not yet taken. carrier_on reflects the level
// after the beat; an accepted start already shows the header mark. A start while busy
// is answered with start_rejected and does not count as a tick.

module pulse_distance_ir_transmitter (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pdirt_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pdirt_pkg::out_t m_data
);

    logic               push;
    pdirt_pkg::out_t    seq_result;
    pdirt_pkg::status_t status;

    assign push = s_valid && s_ready;

    pdirt_seq u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (push),
        .item   (s_data),
        .result (seq_result),
        .status (status)
    );

    pdirt_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (seq_result),
        .not_full(s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_start_idle_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_data.req_type == pdirt_pkg::REQ_START && !status.busy)
            |=> (status.busy && status.mark))
        else $error("start while idle did not begin a frame");

    a_tick_idle_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_data.req_type == pdirt_pkg::REQ_TICK && !status.busy) |=> !status.busy)
        else $error("tick while idle left idle");

    a_busy_ends_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(status.busy) && $past(aresetn))
            |-> $past(push && s_data.req_type == pdirt_pkg::REQ_TICK))
        else $error("frame ended without a tick");

    a_frozen_without_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (!push && $past(aresetn) && aresetn) |=> $stable(status))
        else $error("sequencer state moved without an accepted beat");

endmodule

// ===== rtl/pdirt_seq.sv =====
// segment sequencer: frame state registers and the per-beat next-state logic
// depends on pdirt_pkg

module pdirt_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  pdirt_pkg::in_t   item,
    output pdirt_pkg::out_t  result,
    output pdirt_pkg::status_t status
);

    logic [pdirt_pkg::FrameW-1:0]  shift_reg, shift_next;
    logic [pdirt_pkg::FrameW-1:0]  saved_reg, saved_next;
    logic [pdirt_pkg::PhaseW-1:0]  phase_reg, phase_next;
    logic [pdirt_pkg::BitCntW-1:0] bits_reg, bits_next;
    logic [pdirt_pkg::TickW-1:0]   ticks_reg, ticks_next;
    logic                          mode_reg, mode_next;
    logic                          rep_reg, rep_next;

    logic [pdirt_pkg::PhaseW-1:0]  ph_c;
    logic [pdirt_pkg::BitCntW-1:0] bits_c, bits_dec;
    logic [pdirt_pkg::TickW-1:0]   ticks_c;
    logic                          rep_c;
    logic                          busy_c;
    logic                          rejected;
    logic [7:0]                    byte_b, byte_h, byte_l;
    logic [pdirt_pkg::FrameW-1:0]  tri_frame;

    assign byte_b    = item.frame_data[23:16];
    assign byte_h    = item.frame_data[15:8];
    assign byte_l    = item.frame_data[7:0];
    assign tri_frame = {byte_b, ~byte_b, byte_h, ~byte_h, byte_l, ~byte_l};
    assign bits_dec  = bits_c - 1'b1;

    always_comb begin
        // an unused phase code drops back to idle first
        if (phase_reg == pdirt_pkg::PH_UNUSED) begin
            ph_c    = pdirt_pkg::PH_IDLE;
            ticks_c = '0;
            bits_c  = '0;
            rep_c   = 1'b0;
        end else begin
            ph_c    = phase_reg;
            ticks_c = ticks_reg;
            bits_c  = bits_reg;
            rep_c   = rep_reg;
        end
        busy_c = (ph_c != pdirt_pkg::PH_IDLE);

        shift_next = shift_reg;
        saved_next = saved_reg;
        phase_next = ph_c;
        bits_next  = bits_c;
        ticks_next = ticks_c;
        mode_next  = mode_reg;
        rep_next   = rep_c;
        rejected   = 1'b0;

        if (item.req_type == pdirt_pkg::REQ_START) begin
            if (busy_c) begin
                rejected = 1'b1;
            end else begin
                mode_next  = item.frame_mode;
                rep_next   = 1'b0;
                bits_next  = '0;
                phase_next = pdirt_pkg::PH_HDR_MARK;
                if (item.frame_mode == pdirt_pkg::MODE_TRI) begin
                    saved_next = tri_frame;
                    shift_next = tri_frame;
                    ticks_next = pdirt_pkg::MED_HDR;
                end else begin
                    shift_next = {item.frame_data, 16'h0000};
                    ticks_next = pdirt_pkg::NEC_LEAD_MARK;
                end
            end
        end else if (busy_c) begin
            if (ticks_c > 8'd1) begin
                ticks_next = ticks_c - 1'b1;
            end else begin
                unique case (ph_c)
                    pdirt_pkg::PH_HDR_MARK: begin
                        phase_next = pdirt_pkg::PH_HDR_SPACE;
                        ticks_next = mode_reg ? pdirt_pkg::MED_HDR : pdirt_pkg::NEC_LEAD_SPACE;
                    end
                    pdirt_pkg::PH_HDR_SPACE: begin
                        bits_next  = mode_reg ? pdirt_pkg::MED_BITS : pdirt_pkg::NEC_BITS;
                        phase_next = pdirt_pkg::PH_BIT_MARK;
                        ticks_next = pdirt_pkg::UNIT_TICKS;
                    end
                    pdirt_pkg::PH_BIT_MARK: begin
                        phase_next = pdirt_pkg::PH_BIT_SPACE;
                        if (shift_reg[pdirt_pkg::FrameW-1]) begin
                            ticks_next = mode_reg ? pdirt_pkg::MED_ONE_SPACE
                                                  : pdirt_pkg::NEC_SPACE_ONE;
                        end else begin
                            ticks_next = pdirt_pkg::UNIT_TICKS;
                        end
                    end
                    pdirt_pkg::PH_BIT_SPACE: begin
                        shift_next = {shift_reg[pdirt_pkg::FrameW-2:0], 1'b0};
                        bits_next  = bits_dec;
                        ticks_next = pdirt_pkg::UNIT_TICKS;
                        phase_next = (bits_dec == '0) ? pdirt_pkg::PH_STOP_MARK
                                                      : pdirt_pkg::PH_BIT_MARK;
                    end
                    pdirt_pkg::PH_STOP_MARK: begin
                        if (mode_reg && !rep_c) begin
                            phase_next = pdirt_pkg::PH_GAP_SPACE;
                            ticks_next = pdirt_pkg::MED_GAP_SPACE;
                        end else begin
                            phase_next = pdirt_pkg::PH_IDLE;
                            ticks_next = '0;
                            bits_next  = '0;
                            rep_next   = 1'b0;
                        end
                    end
                    pdirt_pkg::PH_GAP_SPACE: begin
                        rep_next   = 1'b1;
                        shift_next = saved_reg;
                        phase_next = pdirt_pkg::PH_HDR_MARK;
                        ticks_next = pdirt_pkg::MED_HDR;
                    end
                    default: begin
                        phase_next = pdirt_pkg::PH_IDLE;
                        ticks_next = '0;
                        bits_next  = '0;
                        rep_next   = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        result.carrier_on     = (phase_next == pdirt_pkg::PH_HDR_MARK)
                             || (phase_next == pdirt_pkg::PH_BIT_MARK)
                             || (phase_next == pdirt_pkg::PH_STOP_MARK);
        result.busy_res       = (phase_next != pdirt_pkg::PH_IDLE)
                             && (phase_next != pdirt_pkg::PH_UNUSED);
        result.start_rejected = rejected;
    end

    always_comb begin
        status.busy = (phase_reg != pdirt_pkg::PH_IDLE) && (phase_reg != pdirt_pkg::PH_UNUSED);
        status.mark = (phase_reg == pdirt_pkg::PH_HDR_MARK)
                   || (phase_reg == pdirt_pkg::PH_BIT_MARK)
                   || (phase_reg == pdirt_pkg::PH_STOP_MARK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            saved_reg <= '0;
            phase_reg <= pdirt_pkg::PH_IDLE;
            bits_reg  <= '0;
            ticks_reg <= '0;
            mode_reg  <= 1'b0;
            rep_reg   <= 1'b0;
        end else if (step) begin
            shift_reg <= shift_next;
            saved_reg <= saved_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            ticks_reg <= ticks_next;
            mode_reg  <= mode_next;
            rep_reg   <= rep_next;
        end
    end

endmodule

// ===== rtl/pdirt_obuf.sv =====
// two-entry result queue between the sequencer and the result channel
// depends on pdirt_pkg

module pdirt_obuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pdirt_pkg::out_t wr_data,
    output logic            not_full,
    output logic            m_valid,
    input  logic            m_ready,
    output pdirt_pkg::out_t m_data
);

    pdirt_pkg::out_t mem [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (cnt_reg != 2'd0);
    assign not_full = (cnt_reg != 2'd2);
    assign m_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for pulse_distance_ir_transmitter: NEC and three-byte frames,
// idle ticks and starts while busy, under several sender and receiver idling mixes
// depends on pdirt_pkg and the rtl of the block

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PhaseBeats = 286;
    localparam int unsigned NoisePct   = 2;

    class ir_scoreboard;
        logic [pdirt_pkg::FrameW-1:0]  shift_reg;
        logic [pdirt_pkg::FrameW-1:0]  repeat_copy;
        logic [pdirt_pkg::PhaseW-1:0]  seg;
        logic [pdirt_pkg::BitCntW-1:0] bits_rem;
        logic [pdirt_pkg::TickW-1:0]   ticks_rem;
        logic                          mode_r;
        logic                          second_pass;
        pdirt_pkg::out_t               expected_q[$];
        int unsigned                   errors;
        int unsigned                   beats_in;
        int unsigned                   results_seen;
        int unsigned                   nec_frames;
        int unsigned                   tri_frames;
        int unsigned                   rejects;

        function new();
            shift_reg    = '0;
            repeat_copy  = '0;
            seg          = pdirt_pkg::PH_IDLE;
            bits_rem     = '0;
            ticks_rem    = '0;
            mode_r       = pdirt_pkg::MODE_NEC;
            second_pass  = 1'b0;
            errors       = 0;
            beats_in     = 0;
            results_seen = 0;
            nec_frames   = 0;
            tri_frames   = 0;
            rejects      = 0;
        endfunction

        function bit is_busy();
            return seg >= pdirt_pkg::PH_HDR_MARK && seg <= pdirt_pkg::PH_GAP_SPACE;
        endfunction

        function bit is_mark();
            return seg == pdirt_pkg::PH_HDR_MARK || seg == pdirt_pkg::PH_BIT_MARK
                || seg == pdirt_pkg::PH_STOP_MARK;
        endfunction

        function void enter_segment(logic [pdirt_pkg::PhaseW-1:0] next_seg,
                                    logic [pdirt_pkg::TickW-1:0] len);
            seg       = next_seg;
            ticks_rem = len;
        endfunction

        function void go_idle();
            seg         = pdirt_pkg::PH_IDLE;
            ticks_rem   = '0;
            bits_rem    = '0;
            second_pass = 1'b0;
        endfunction

        function void end_segment();
            case (seg)
                pdirt_pkg::PH_HDR_MARK:
                    enter_segment(pdirt_pkg::PH_HDR_SPACE,
                                  mode_r == pdirt_pkg::MODE_TRI ? pdirt_pkg::MED_HDR
                                                                : pdirt_pkg::NEC_LEAD_SPACE);
                pdirt_pkg::PH_HDR_SPACE: begin
                    bits_rem = (mode_r == pdirt_pkg::MODE_TRI) ? pdirt_pkg::MED_BITS
                                                               : pdirt_pkg::NEC_BITS;
                    enter_segment(pdirt_pkg::PH_BIT_MARK, pdirt_pkg::UNIT_TICKS);
                end
                pdirt_pkg::PH_BIT_MARK: begin
                    if (shift_reg[pdirt_pkg::FrameW-1])
                        enter_segment(pdirt_pkg::PH_BIT_SPACE,
                                      mode_r == pdirt_pkg::MODE_TRI ? pdirt_pkg::MED_ONE_SPACE
                                                                    : pdirt_pkg::NEC_SPACE_ONE);
                    else
                        enter_segment(pdirt_pkg::PH_BIT_SPACE, pdirt_pkg::UNIT_TICKS);
                end
                pdirt_pkg::PH_BIT_SPACE: begin
                    shift_reg = shift_reg << 1;
                    bits_rem  = bits_rem - 1'b1;
                    if (bits_rem == '0)
                        enter_segment(pdirt_pkg::PH_STOP_MARK, pdirt_pkg::UNIT_TICKS);
                    else
                        enter_segment(pdirt_pkg::PH_BIT_MARK, pdirt_pkg::UNIT_TICKS);
                end
                pdirt_pkg::PH_STOP_MARK: begin
                    if (mode_r == pdirt_pkg::MODE_TRI && !second_pass)
                        enter_segment(pdirt_pkg::PH_GAP_SPACE, pdirt_pkg::MED_GAP_SPACE);
                    else
                        go_idle();
                end
                pdirt_pkg::PH_GAP_SPACE: begin
                    second_pass = 1'b1;
                    shift_reg   = repeat_copy;
                    enter_segment(pdirt_pkg::PH_HDR_MARK, pdirt_pkg::MED_HDR);
                end
                default: go_idle();
            endcase
        endfunction

        function void note_beat(pdirt_pkg::in_t beat);
            logic                         rej;
            logic [pdirt_pkg::FrameW-1:0] tri_word;
            pdirt_pkg::out_t              exp_res;
            rej = 1'b0;
            beats_in++;
            if (!is_busy() && seg != pdirt_pkg::PH_IDLE)
                go_idle();
            if (beat.req_type == pdirt_pkg::REQ_START) begin
                if (is_busy()) begin
                    rej = 1'b1;
                    rejects++;
                end else begin
                    mode_r      = beat.frame_mode;
                    second_pass = 1'b0;
                    bits_rem    = '0;
                    if (beat.frame_mode == pdirt_pkg::MODE_TRI) begin
                        tri_word = {beat.frame_data[23:16], ~beat.frame_data[23:16],
                                    beat.frame_data[15:8], ~beat.frame_data[15:8],
                                    beat.frame_data[7:0], ~beat.frame_data[7:0]};
                        repeat_copy = tri_word;
                        shift_reg   = tri_word;
                        enter_segment(pdirt_pkg::PH_HDR_MARK, pdirt_pkg::MED_HDR);
                        tri_frames++;
                    end else begin
                        shift_reg = {beat.frame_data, 16'h0000};
                        enter_segment(pdirt_pkg::PH_HDR_MARK, pdirt_pkg::NEC_LEAD_MARK);
                        nec_frames++;
                    end
                end
            end else if (is_busy()) begin
                if (ticks_rem > 1)
                    ticks_rem = ticks_rem - 1'b1;
                else
                    end_segment();
            end
            exp_res.carrier_on     = is_mark();
            exp_res.busy_res       = is_busy();
            exp_res.start_rejected = rej;
            expected_q.push_back(exp_res);
        endfunction

        function void check_result(pdirt_pkg::out_t got);
            pdirt_pkg::out_t exp_res;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %b", $time, got);
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.carrier_on !== exp_res.carrier_on) begin
                errors++;
                $display("%0t: carrier_on mismatch, expected %b, actual %b",
                         $time, exp_res.carrier_on, got.carrier_on);
            end
            if (got.busy_res !== exp_res.busy_res) begin
                errors++;
                $display("%0t: busy_res mismatch, expected %b, actual %b",
                         $time, exp_res.busy_res, got.busy_res);
            end
            if (got.start_rejected !== exp_res.start_rejected) begin
                errors++;
                $display("%0t: start_rejected mismatch, expected %b, actual %b",
                         $time, exp_res.start_rejected, got.start_rejected);
            end
        endfunction
    endclass

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    pdirt_pkg::in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    pdirt_pkg::out_t m_data;

    ir_scoreboard sb;
    int unsigned  tx_idle_pct;
    int unsigned  rx_stall_pct;
    logic         next_mode;

    pulse_distance_ir_transmitter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #500us;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, check at the rising edge
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_data);
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_beat(input pdirt_pkg::in_t beat);
        int unsigned gap;
        gap = 0;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_beat(beat);
    endtask

    task automatic send_tick();
        pdirt_pkg::in_t beat;
        beat.req_type   = pdirt_pkg::REQ_TICK;
        beat.frame_mode = 1'($urandom_range(1));
        beat.frame_data = $urandom;
        send_beat(beat);
    endtask

    task automatic send_start(input logic mode, input logic [pdirt_pkg::DataW-1:0] data);
        pdirt_pkg::in_t beat;
        beat.req_type   = pdirt_pkg::REQ_START;
        beat.frame_mode = mode;
        beat.frame_data = data;
        send_beat(beat);
    endtask

    // next beat of the stream: a new frame when idle, else ticks with stray starts
    task automatic send_next();
        if (!sb.is_busy()) begin
            send_start(next_mode, $urandom);
            next_mode = ~next_mode;
        end else if ($urandom_range(99) < NoisePct) begin
            send_start(1'($urandom_range(1)), $urandom);
        end else begin
            send_tick();
        end
    endtask

    initial begin
        int unsigned drain;
        int unsigned p;
        sb           = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        next_mode    = pdirt_pkg::MODE_TRI;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: idle ticks, an NEC word with both bit values, starts while busy
        send_tick();
        send_tick();
        send_start(pdirt_pkg::MODE_NEC, 32'h8000_0001);
        send_start(pdirt_pkg::MODE_TRI, 32'h0000_0000);
        send_start(pdirt_pkg::MODE_NEC, 32'hFFFF_FFFF);

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 63;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 63;
                end
                default: begin
                    tx_idle_pct  = 15;
                    rx_stall_pct = 15;
                end
            endcase
            repeat (PhaseBeats) send_next();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        drain = 0;
        while (sb.expected_q.size() != 0 && drain < 10000) begin
            @(posedge aclk);
            drain++;
        end
        if (sb.expected_q.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
        end
        repeat (16) @(posedge aclk);

        $display("%0d beats sent, %0d results checked, %0d NEC and %0d three-byte frames,",
                 sb.beats_in, sb.results_seen, sb.nec_frames, sb.tri_frames);
        $display("%0d starts rejected while busy, over four idling mixes, %0d errors",
                 sb.rejects, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pdirt_pkg.sv
rtl/pdirt_seq.sv
rtl/pdirt_obuf.sv
rtl/pulse_distance_ir_transmitter.sv
sim/tb_top.sv
